### sv/assert_macros.svh
// Assertion macros shared by the allocator RTL.
// Depends on nothing; every user has aclk and aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every edge outside reset.
`define FFCA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Condition implies a consequence in the next cycle.
`define FFCA_ASSERT_NEXT(lbl, cond, nxt, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (nxt)) \
        else $error(msg);

`endif

### sv/ffca_pkg.sv
// Shared types and constants of the first-fit allocator.
// Depends on nothing.
`default_nettype none

package ffca_pkg;

    localparam int NUM_CELLS   = 1024;
    localparam int MAX_OBJECTS = 256;
    localparam int CELL_AW     = $clog2(NUM_CELLS);
    localparam int CNT_W       = CELL_AW + 1;
    localparam int ID_W        = 8;
    localparam int QDEPTH      = 2;

    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_CLR3  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_ALLOCATED = 3'd0,
        ST_PRESENT   = 3'd1,
        ST_NO_ROOM   = 3'd2,
        ST_FREED     = 3'd3,
        ST_UNKNOWN   = 3'd4,
        ST_CLEARED   = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        OP_ALLOC,
        OP_FREE,
        OP_CLEAR,
        OP_NOROOM
    } op_t;

    typedef enum logic [2:0] {
        BK_INIT,
        BK_IDLE,
        BK_SCAN,
        BK_FREE_RD,
        BK_MARK,
        BK_RESP
    } bk_state_t;

    typedef struct packed {
        op_t             op;
        logic [ID_W-1:0] id;
        logic [CNT_W-1:0] len;
    } q_entry_t;

    typedef struct packed {
        logic     valid;
        q_entry_t entry;
    } front_to_back_t;

    typedef struct packed {
        logic pop;
        logic accept_ok;
    } back_to_front_t;

endpackage

`default_nettype wire

### sv/ffca_front.sv
// Front end: accepts commands, classifies them and queues them for the back end.
// Depends on ffca_pkg.
`default_nettype none

module ffca_front import ffca_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [1:0]        s_command,
    input  wire logic [ID_W-1:0]   s_object_id,
    input  wire logic [CNT_W-1:0]  s_run_length,
    output front_to_back_t         to_back,
    input  wire back_to_front_t    from_back
);

    q_entry_t queue_reg [QDEPTH];
    logic     wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    q_entry_t cls;
    logic     push;

    always_comb begin
        cls.id  = s_object_id;
        cls.len = s_run_length;
        unique case (cmd_t'(s_command))
            CMD_ALLOC: begin
                if (s_run_length == '0 || s_run_length > CNT_W'(NUM_CELLS)) begin
                    cls.op = OP_NOROOM;
                end else begin
                    cls.op = OP_ALLOC;
                end
            end
            CMD_FREE: cls.op = OP_FREE;
            default:  cls.op = OP_CLEAR;
        endcase
    end

    assign s_ready = (count_reg != 2'(QDEPTH)) && from_back.accept_ok;
    assign push    = s_valid && s_ready;

    assign to_back.valid = (count_reg != '0);
    assign to_back.entry = queue_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= cls;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (from_back.pop) rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(from_back.pop);
        end
    end

endmodule

`default_nettype wire

### sv/ffca_back.sv
// Back end: executes queued commands against the cell map and object table.
// Depends on ffca_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ffca_back import ffca_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire front_to_back_t    from_front,
    output back_to_front_t         to_front,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [2:0]             m_status,
    output logic [CELL_AW-1:0]     m_start_cell,
    output logic [CNT_W-1:0]       m_free_count
);

    // cell occupancy map, one bit per cell
    logic cell_mem [NUM_CELLS];
    logic cell_rd_reg;
    // object table
    logic [CELL_AW-1:0] obj_start_mem [MAX_OBJECTS];
    logic [CNT_W-1:0]   obj_len_mem   [MAX_OBJECTS];
    logic [CELL_AW-1:0] obj_start_rd_reg;
    logic [CNT_W-1:0]   obj_len_rd_reg;

    bk_state_t state_reg, state_next;
    logic [MAX_OBJECTS-1:0] present_reg, present_next;
    logic [CNT_W-1:0]   free_total_reg, free_total_next;
    logic [CELL_AW-1:0] addr_reg, addr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CELL_AW-1:0] chk_addr_reg, chk_addr_next;
    logic               chk_valid_reg, chk_valid_next;
    logic               mark_val_reg, mark_val_next;
    logic               init_resp_reg, init_resp_next;
    logic [ID_W-1:0]    id_reg, id_next;
    logic [CNT_W-1:0]   len_reg, len_next;
    status_t            res_status_reg, res_status_next;
    logic [CELL_AW-1:0] res_start_reg, res_start_next;
    logic               out_valid_reg, out_valid_next;
    logic [2:0]         out_status_reg, out_status_next;
    logic [CELL_AW-1:0] out_start_reg, out_start_next;
    logic [CNT_W-1:0]   out_free_reg, out_free_next;

    logic               cell_we, cell_wd;
    logic [CELL_AW-1:0] cell_wa;
    logic               obj_we;
    logic [CELL_AW-1:0] found_start;
    logic [CNT_W-1:0]   run_inc;
    logic               resp_fire;

    assign found_start = CELL_AW'({1'b0, chk_addr_reg} + CNT_W'(1) - len_reg);
    assign run_inc     = cnt_reg + CNT_W'(1);
    assign resp_fire   = (state_reg == BK_RESP) && (!out_valid_reg || m_ready);

    always_comb begin
        state_next      = state_reg;
        present_next    = present_reg;
        free_total_next = free_total_reg;
        addr_next       = addr_reg;
        cnt_next        = cnt_reg;
        chk_addr_next   = chk_addr_reg;
        chk_valid_next  = chk_valid_reg;
        mark_val_next   = mark_val_reg;
        init_resp_next  = init_resp_reg;
        id_next         = id_reg;
        len_next        = len_reg;
        res_status_next = res_status_reg;
        res_start_next  = res_start_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        out_status_next = out_status_reg;
        out_start_next  = out_start_reg;
        out_free_next   = out_free_reg;
        cell_we         = 1'b0;
        cell_wa         = addr_reg;
        cell_wd         = mark_val_reg;
        obj_we          = 1'b0;
        to_front.pop    = 1'b0;
        to_front.accept_ok = !(state_reg == BK_INIT && !init_resp_reg);

        unique case (state_reg)
            BK_INIT: begin
                cell_we   = 1'b1;
                cell_wd   = 1'b0;
                addr_next = addr_reg + CELL_AW'(1);
                if (addr_reg == CELL_AW'(NUM_CELLS - 1)) begin
                    state_next = init_resp_reg ? BK_RESP : BK_IDLE;
                end
            end
            BK_IDLE: begin
                if (from_front.valid) begin
                    to_front.pop   = 1'b1;
                    id_next        = from_front.entry.id;
                    len_next       = from_front.entry.len;
                    res_start_next = '0;
                    state_next     = BK_RESP;
                    unique case (from_front.entry.op)
                        OP_CLEAR: begin
                            present_next    = '0;
                            free_total_next = CNT_W'(NUM_CELLS);
                            addr_next       = '0;
                            init_resp_next  = 1'b1;
                            res_status_next = ST_CLEARED;
                            state_next      = BK_INIT;
                        end
                        // a present id wins over a length that can never fit
                        OP_NOROOM: begin
                            if (present_reg[from_front.entry.id]) begin
                                res_status_next = ST_PRESENT;
                            end else begin
                                res_status_next = ST_NO_ROOM;
                            end
                        end
                        OP_ALLOC: begin
                            if (present_reg[from_front.entry.id]) begin
                                res_status_next = ST_PRESENT;
                            end else if (from_front.entry.len > free_total_reg) begin
                                res_status_next = ST_NO_ROOM;
                            end else begin
                                addr_next      = '0;
                                cnt_next       = '0;
                                chk_valid_next = 1'b0;
                                state_next     = BK_SCAN;
                            end
                        end
                        default: begin
                            if (!present_reg[from_front.entry.id]) begin
                                res_status_next = ST_UNKNOWN;
                            end else begin
                                state_next = BK_FREE_RD;
                            end
                        end
                    endcase
                end
            end
            BK_SCAN: begin
                // read issued in the cycle before its check
                addr_next      = addr_reg + CELL_AW'(1);
                chk_addr_next  = addr_reg;
                chk_valid_next = 1'b1;
                if (chk_valid_reg) begin
                    if (cell_rd_reg) begin
                        cnt_next = '0;
                    end else begin
                        cnt_next = run_inc;
                    end
                    if (!cell_rd_reg && run_inc == len_reg) begin
                        addr_next             = found_start;
                        cnt_next              = len_reg;
                        mark_val_next         = 1'b1;
                        present_next[id_reg]  = 1'b1;
                        obj_we                = 1'b1;
                        free_total_next       = free_total_reg - len_reg;
                        res_status_next       = ST_ALLOCATED;
                        res_start_next        = found_start;
                        state_next            = BK_MARK;
                    end else if (chk_addr_reg == CELL_AW'(NUM_CELLS - 1)) begin
                        res_status_next = ST_NO_ROOM;
                        state_next      = BK_RESP;
                    end
                end
            end
            BK_FREE_RD: begin
                addr_next            = obj_start_rd_reg;
                cnt_next             = obj_len_rd_reg;
                mark_val_next        = 1'b0;
                present_next[id_reg] = 1'b0;
                free_total_next      = free_total_reg + obj_len_rd_reg;
                res_status_next      = ST_FREED;
                res_start_next       = obj_start_rd_reg;
                state_next           = BK_MARK;
            end
            BK_MARK: begin
                cell_we   = 1'b1;
                addr_next = addr_reg + CELL_AW'(1);
                cnt_next  = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    state_next = BK_RESP;
                end
            end
            BK_RESP: begin
                if (resp_fire) begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_start_next  = res_start_reg;
                    out_free_next   = free_total_reg;
                    init_resp_next  = 1'b0;
                    state_next      = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cell_we) begin
            cell_mem[cell_wa] <= cell_wd;
        end
        cell_rd_reg <= cell_mem[addr_reg];
    end

    always_ff @(posedge aclk) begin
        if (obj_we) begin
            obj_start_mem[id_reg] <= found_start;
            obj_len_mem[id_reg]   <= len_reg;
        end
        obj_start_rd_reg <= obj_start_mem[from_front.entry.id];
        obj_len_rd_reg   <= obj_len_mem[from_front.entry.id];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= BK_INIT;
            present_reg    <= '0;
            free_total_reg <= CNT_W'(NUM_CELLS);
            addr_reg       <= '0;
            init_resp_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            chk_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            present_reg    <= present_next;
            free_total_reg <= free_total_next;
            addr_reg       <= addr_next;
            init_resp_reg  <= init_resp_next;
            out_valid_reg  <= out_valid_next;
            chk_valid_reg  <= chk_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg        <= cnt_next;
        chk_addr_reg   <= chk_addr_next;
        mark_val_reg   <= mark_val_next;
        id_reg         <= id_next;
        len_reg        <= len_next;
        res_status_reg <= res_status_next;
        res_start_reg  <= res_start_next;
        out_status_reg <= out_status_next;
        out_start_reg  <= out_start_next;
        out_free_reg   <= out_free_next;
    end

    assign m_valid      = out_valid_reg;
    assign m_status     = out_status_reg;
    assign m_start_cell = out_start_reg;
    assign m_free_count = out_free_reg;

    `FFCA_ASSERT(a_free_range, free_total_reg <= CNT_W'(NUM_CELLS), "free total out of range")
    `FFCA_ASSERT(a_mark_cnt, state_reg != BK_MARK || cnt_reg != '0, "mark with zero count")
    `FFCA_ASSERT_NEXT(a_resp_load, resp_fire, out_valid_reg && state_reg == BK_IDLE, "no load")

endmodule

`default_nettype wire

### sv/first_fit_contiguous_allocator.sv
// Channel  Ports                                          Dir
// s_       s_valid s_ready s_command s_object_id s_run_length   in
// m_       m_valid m_ready m_status m_start_cell m_free_count   out
//
// Allocate scans the cell map one cell a cycle, then marks the cells it
// takes. Free reads the object table, then clears the object's cells.
// Clear and reset sweep the whole cell map; after reset s_ready
// stays low for that sweep. A two-entry queue keeps taking commands, until full, while
// the back end works or a result waits on m_ready.
// Top level: front classifier/queue and back executor. Depends on ffca_pkg, ffca_front and ffca_back.
`default_nettype none

module first_fit_contiguous_allocator import ffca_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [1:0]        s_command,
    input  wire logic [ID_W-1:0]   s_object_id,
    input  wire logic [CNT_W-1:0]  s_run_length,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [2:0]             m_status,
    output logic [CELL_AW-1:0]     m_start_cell,
    output logic [CNT_W-1:0]       m_free_count
);

    front_to_back_t f2b;
    back_to_front_t b2f;

    ffca_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_command    (s_command),
        .s_object_id  (s_object_id),
        .s_run_length (s_run_length),
        .to_back      (f2b),
        .from_back    (b2f)
    );

    ffca_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .from_front   (f2b),
        .to_front     (b2f),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_start_cell (m_start_cell),
        .m_free_count (m_free_count)
    );

endmodule

`default_nettype wire

### verif/first_fit_contiguous_allocator_tb.sv
// Testbench for first_fit_contiguous_allocator: predicts each result with its own
// first-fit occupancy model and checks words from the result channel in order.
// Depends on ffca_pkg and the allocator RTL.
`default_nettype none

module first_fit_contiguous_allocator_tb;
    import ffca_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]       command;
        logic [ID_W-1:0]  object_id;
        logic [CNT_W-1:0] run_length;
    } cmd_word_t;

    typedef struct packed {
        status_t            status;
        logic [CELL_AW-1:0] start_cell;
        logic [CNT_W-1:0]   free_count;
    } result_word_t;

    localparam int IDLE_LIMIT = 200000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [1:0] s_command = '0;
    logic [ID_W-1:0] s_object_id = '0;
    logic [CNT_W-1:0] s_run_length = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [2:0] m_status;
    logic [CELL_AW-1:0] m_start_cell;
    logic [CNT_W-1:0] m_free_count;

    first_fit_contiguous_allocator i_dut (.*);

    always #5 aclk = ~aclk;

    // predictor state
    bit cell_busy [NUM_CELLS];
    bit id_live [MAX_OBJECTS];
    int id_start [MAX_OBJECTS];
    int id_len [MAX_OBJECTS];
    int cells_free = NUM_CELLS;

    cmd_word_t pending_cmds[$];
    result_word_t expected_results[$];
    int errors = 0;
    int n_sent = 0, n_checked = 0, n_alloc_ok = 0, n_freed = 0;
    int idle_cycles = 0;
    bit hold_sender = 0;
    bit calm = 0;
    int s_gap = 0, m_gap = 0;

    function automatic result_word_t predict_result(cmd_word_t c);
        result_word_t r;
        int len, run, st;
        r.status = ST_NO_ROOM;
        r.start_cell = '0;
        if (c.command[1]) begin
            foreach (cell_busy[i]) cell_busy[i] = 0;
            foreach (id_live[i]) id_live[i] = 0;
            cells_free = NUM_CELLS;
            r.status = ST_CLEARED;
        end else if (c.command == CMD_ALLOC) begin
            len = c.run_length;
            st = -1;
            if (id_live[c.object_id]) begin
                r.status = ST_PRESENT;
            end else if (len >= 1 && len <= NUM_CELLS) begin
                run = 0;
                for (int i = 0; i < NUM_CELLS; i++) begin
                    run = cell_busy[i] ? 0 : run + 1;
                    if (run == len) begin
                        st = i + 1 - len;
                        break;
                    end
                end
            end
            if (st >= 0) begin
                for (int i = st; i < st + len; i++) cell_busy[i] = 1;
                id_live[c.object_id] = 1;
                id_start[c.object_id] = st;
                id_len[c.object_id] = len;
                cells_free -= len;
                r.status = ST_ALLOCATED;
                r.start_cell = CELL_AW'(st);
            end
        end else begin
            if (!id_live[c.object_id]) begin
                r.status = ST_UNKNOWN;
            end else begin
                for (int i = 0; i < id_len[c.object_id]; i++)
                    cell_busy[id_start[c.object_id] + i] = 0;
                id_live[c.object_id] = 0;
                cells_free += id_len[c.object_id];
                r.status = ST_FREED;
                r.start_cell = CELL_AW'(id_start[c.object_id]);
            end
        end
        r.free_count = CNT_W'(cells_free);
        return r;
    endfunction

    function automatic cmd_word_t make_cmd(logic [1:0] op, int id, int len);
        cmd_word_t c;
        c.command = op;
        c.object_id = ID_W'(id);
        c.run_length = CNT_W'(len);
        return c;
    endfunction

    function automatic void add_cmd(logic [1:0] op, int id, int len);
        pending_cmds.insert(pending_cmds.size(), make_cmd(op, id, len));
    endfunction

    // driver
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_results.insert(expected_results.size(), predict_result(
                    make_cmd(s_command, s_object_id, s_run_length)));
                n_sent++;
            end
            if (!s_valid || s_ready) begin
                if (s_gap > 0) begin
                    s_gap--;
                    s_valid <= 1'b0;
                end else if (pending_cmds.size() > 0 && !hold_sender) begin
                    s_valid <= 1'b1;
                    {s_command, s_object_id, s_run_length} <= pending_cmds.pop_front();
                    if (!calm && $urandom_range(0, 9) == 0) s_gap = $urandom_range(1, 18);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and result-side stalls
    always @(posedge aclk) begin
        result_word_t exp_r;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                n_checked++;
                if (expected_results.size() == 0) begin
                    $error("result word with nothing expected");
                    errors++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (m_status !== exp_r.status) begin
                        $error("status expected %0d got %0d", exp_r.status, m_status);
                        errors++;
                    end
                    if (m_start_cell !== exp_r.start_cell) begin
                        $error("start_cell expected %0d got %0d",
                               exp_r.start_cell, m_start_cell);
                        errors++;
                    end
                    if (m_free_count !== exp_r.free_count) begin
                        $error("free_count expected %0d got %0d",
                               exp_r.free_count, m_free_count);
                        errors++;
                    end
                    if (exp_r.status == ST_ALLOCATED) n_alloc_ok++;
                    if (exp_r.status == ST_FREED) n_freed++;
                end
            end
            if (m_gap > 0) begin
                m_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (!calm && $urandom_range(0, 9) == 0) m_gap = $urandom_range(1, 18);
            end
        end
    end

    // watchdog: counts cycles with no accepted word on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
            $display("first_fit_contiguous_allocator verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int id, len, pick;
        int live_ids[$];
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, every command, the special cases
        add_cmd(CMD_FREE, 0, 0);          // free of absent id
        add_cmd(CMD_ALLOC, 0, 0);         // zero length
        add_cmd(CMD_ALLOC, 1, 1025);      // longer than store
        add_cmd(CMD_ALLOC, 2, 2047);
        add_cmd(CMD_ALLOC, 255, 1024);    // whole store
        add_cmd(CMD_ALLOC, 3, 1);         // full: no room
        add_cmd(CMD_ALLOC, 255, 5);       // id present
        add_cmd(CMD_ALLOC, 255, 0);       // id present beats zero length
        add_cmd(CMD_FREE, 255, 0);
        add_cmd(CMD_ALLOC, 10, 10);
        add_cmd(CMD_ALLOC, 11, 20);
        add_cmd(CMD_ALLOC, 12, 994);      // ends on last cell
        add_cmd(CMD_FREE, 10, 0);
        add_cmd(CMD_ALLOC, 13, 11);       // hole too small
        add_cmd(CMD_ALLOC, 14, 10);       // exact fit in hole
        add_cmd(CMD_CLR3, 0, 0);          // command three clears
        add_cmd(CMD_ALLOC, 20, 1023);
        add_cmd(CMD_ALLOC, 21, 1);
        add_cmd(CMD_CLEAR, 8'hAA, 11'h555);
        add_cmd(CMD_FREE, 21, 11'h7FF);

        while (pending_cmds.size() > 0 || s_valid || expected_results.size() > 0)
            @(posedge aclk);
        // once everything is back, the sender is held off before the random phase
        hold_sender = 1;
        repeat (20) @(posedge aclk);
        hold_sender = 0;

        // random: mostly allocate on random ids and free ids sent to allocate, with noise and clears
        for (int i = 0; i < 400; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                id = $urandom_range(0, 255);
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 2047)
                                                   : $urandom_range(1, 64);
                add_cmd(CMD_ALLOC, id, len);
                live_ids.insert(live_ids.size(), id);
            end else if (pick < 88 && live_ids.size() > 0) begin
                pick = $urandom_range(0, live_ids.size() - 1);
                add_cmd(CMD_FREE, live_ids[pick], $urandom_range(0, 2047));
                live_ids.delete(pick);
            end else if (pick < 96) begin
                add_cmd(CMD_FREE, $urandom_range(0, 255), $urandom_range(0, 2047));
            end else begin
                add_cmd(2'($urandom_range(2, 3)),
                        $urandom_range(0, 255), $urandom_range(0, 2047));
                live_ids.delete();
            end
        end

        // last stretch runs without idling
        while (pending_cmds.size() > 60) @(posedge aclk);
        calm = 1;

        while (pending_cmds.size() > 0 || s_valid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (2100) @(posedge aclk);

        $display("sent %0d commands, checked %0d results", n_sent, n_checked);
        $display("successful allocations %0d, frees %0d", n_alloc_ok, n_freed);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("first_fit_contiguous_allocator verification clean");
        end else begin
            $display("first_fit_contiguous_allocator verification failed");
        end
        $finish;
    end
endmodule

`default_nettype wire

### first_fit_contiguous_allocator.f
+incdir+sv
sv/ffca_pkg.sv
sv/ffca_front.sv
sv/ffca_back.sv
sv/first_fit_contiguous_allocator.sv
verif/first_fit_contiguous_allocator_tb.sv
